FILE: sv/bfsa_pkg.sv
`default_nettype none
package bfsa_pkg;
    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_INIT   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADFREE = 2'd2
    } status_t;

    localparam logic CFG_HEAP_BASE   = 1'b0;
    localparam logic CFG_HEAP_LENGTH = 1'b1;
    localparam logic [31:0] RESET_HEAP_BASE   = 32'd65536;
    localparam logic [31:0] RESET_HEAP_LENGTH = 32'd65536;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // latch request
        logic scan_start; // clear scan index and best tracking
        logic rd;         // issue table read at scan index
        logic eval;       // evaluate returned entry
        logic commit;     // write granted entry / free entry
        logic shift_rd;   // read entry below shift index
        logic shift_wr;   // write it one place up
        logic ins;        // write split entry
        logic init_wr;    // write init entry at init index
        logic init_done;  // set count to one
        logic done;       // form result
    } cmd_t;

    typedef struct packed {
        logic scan_last;  // scan index at last valid entry
        logic found;      // free scan or fit found
        logic do_split;   // split condition
        logic shift_end;  // shift index reached best+1
        logic init_last;  // init index at last entry
        func_t func;
    } sts_t;
endpackage
`default_nettype wire

FILE: sv/bfsa_datapath.sv
`default_nettype none
module bfsa_datapath #(
    parameter int MAX_CHUNKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bfsa_pkg::cmd_t    cmd,
    output bfsa_pkg::sts_t         sts,
    input  wire logic [1:0]        func,
    input  wire logic [31:0]       size_bytes,
    input  wire logic [31:0]       address,
    input  wire logic [31:0]       heap_base,
    input  wire logic [31:0]       heap_length,
    output logic [31:0]            payload_address,
    output logic [1:0]             status,
    output logic                   split_done
);
    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHUNKS);
    localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);

    // entry: {used, length, start}
    logic [64:0] mem [MAX_CHUNKS];
    logic [64:0] rd_data_reg;

    logic [1:0]    func_reg;
    logic [32:0]   need_reg;
    logic [31:0]   addr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] best_reg, best_next;
    logic [31:0]   best_len_reg, best_len_next;
    logic [31:0]   best_start_reg, best_start_next;
    logic          found_reg, found_next;
    logic [CW-1:0] shift_reg, shift_next;
    logic [31:0]   pay_reg, pay_next;
    logic [1:0]    status_reg, status_next;
    logic          split_reg, split_next;

    logic [31:0] e_start, e_len;
    logic        e_used, fit, better, match;
    logic [32:0] left33;
    logic        do_split;

    assign e_start = rd_data_reg[31:0];
    assign e_len   = rd_data_reg[63:32];
    assign e_used  = rd_data_reg[64];
    assign fit     = !e_used && ({1'b0, e_len} >= need_reg);
    assign better  = !found_reg || (e_len < best_len_reg);
    assign match   = e_used && ((e_start + 32'(HEADER_BYTES)) == addr_reg);
    assign left33  = {1'b0, best_len_reg} - need_reg;
    assign do_split = (left33 > HDR33) && (count_reg < CNT_MAX);

    assign sts.scan_last = ({1'b0, idx_reg} + 1'b1) >= (IW+1)'(count_reg);
    assign sts.found     = found_reg;
    assign sts.do_split  = do_split;
    assign sts.shift_end = shift_reg <= (CW'(best_reg) + 1'b1);
    assign sts.init_last = idx_reg == IW'(MAX_CHUNKS - 1);
    assign sts.func      = bfsa_pkg::func_t'(func_reg);

    always_ff @(posedge clk) begin
        if (cmd.rd)
            rd_data_reg <= mem[idx_reg];
        else if (cmd.shift_rd)
            rd_data_reg <= mem[IW'(shift_reg - 1'b1)];
        if (cmd.init_wr)
            mem[idx_reg] <= (idx_reg == '0) ? {1'b0, heap_length, heap_base} : '0;
        else if (cmd.commit)
            mem[best_reg] <= (func_reg == bfsa_pkg::FUNC_ALLOC)
                ? {1'b1, need_reg[31:0], best_start_reg}
                : {1'b0, best_len_reg, best_start_reg};
        else if (cmd.shift_wr)
            mem[IW'(shift_reg)] <= rd_data_reg;
        else if (cmd.ins)
            mem[IW'(best_reg + 1'b1)] <= {1'b0, 32'(left33 - HDR33),
                best_start_reg + 32'(HEADER_BYTES) + need_reg[31:0]};
        if (cmd.load)
        begin
            func_reg <= func;
            need_reg <= ({1'b0, size_bytes} + 33'd3) & ~33'd3;
            addr_reg <= address;
        end
    end

    always_comb
    begin
        idx_next = idx_reg; best_next = best_reg; best_len_next = best_len_reg;
        best_start_next = best_start_reg; found_next = found_reg;
        shift_next = shift_reg; count_next = count_reg;
        pay_next = pay_reg; status_next = status_reg; split_next = split_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0; found_next = 1'b0;
        end
        if (cmd.eval)
        begin
            if (func_reg == bfsa_pkg::FUNC_ALLOC) begin
                if (fit && better)
                begin
                    found_next = 1'b1; best_next = idx_reg;
                    best_len_next = e_len; best_start_next = e_start;
                end
            end else if (match && !found_reg)
            begin
                found_next = 1'b1; best_next = idx_reg;
                best_len_next = e_len; best_start_next = e_start;
            end
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.commit)
            shift_next = count_reg;
        if (cmd.shift_wr)
            shift_next = shift_reg - 1'b1;
        if (cmd.ins)
            count_next = count_reg + 1'b1;
        if (cmd.init_wr)
            idx_next = idx_reg + 1'b1;
        if (cmd.init_done)
            count_next = CW'(1);
        if (cmd.done)
        begin
            pay_next = '0; split_next = 1'b0; status_next = bfsa_pkg::ST_DONE;
            unique case (bfsa_pkg::func_t'(func_reg))
                bfsa_pkg::FUNC_ALLOC:
                    if (!found_reg) status_next = bfsa_pkg::ST_NOFIT;
                    else
                    begin
                        pay_next = best_start_reg + 32'(HEADER_BYTES);
                        split_next = cmd.ins;
                    end
                bfsa_pkg::FUNC_FREE:
                    if (!found_reg) status_next = bfsa_pkg::ST_BADFREE;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1);
            idx_reg <= '0; best_reg <= '0; found_reg <= 1'b0; shift_reg <= '0;
        end else
        begin
            count_reg <= count_next; idx_reg <= idx_next; best_reg <= best_next;
            found_reg <= found_next; shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_len_reg <= best_len_next; best_start_reg <= best_start_next;
        pay_reg <= pay_next; status_reg <= status_next; split_reg <= split_next;
    end

    assign payload_address = pay_reg;
    assign status          = status_reg;
    assign split_done      = split_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(1) && count_reg <= CNT_MAX)
        else $error("chunk count out of range");
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> count_reg < CNT_MAX)
        else $error("insert with full table");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("count did not advance on insert");
endmodule
`default_nettype wire

FILE: sv/bfsa_ctrl.sv
`default_nettype none
module bfsa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bfsa_pkg::cmd_t      cmd,
    input  wire bfsa_pkg::sts_t sts
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DEC    = 10'b0000000010,
        S_RD     = 10'b0000000100,
        S_EVAL   = 10'b0000001000,
        S_COMMIT = 10'b0000010000,
        S_SHRD   = 10'b0000100000,
        S_SHWR   = 10'b0001000000,
        S_INIT   = 10'b0010000000,
        S_DONE   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   split_reg, split_next;
    logic   boot_reg, boot_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        split_next = split_reg;
        boot_next = boot_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1; cmd.scan_start = 1'b1;
                    split_next = 1'b0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
                unique case (sts.func) inside
                    bfsa_pkg::FUNC_ALLOC, bfsa_pkg::FUNC_FREE: state_next = S_RD;
                    bfsa_pkg::FUNC_INIT: state_next = S_INIT;
                    default: state_next = S_DONE;
                endcase
            S_RD:
            begin
                cmd.rd = 1'b1; state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = sts.scan_last ? S_COMMIT : S_RD;
            end
            S_COMMIT:
                if (!sts.found) state_next = S_DONE;
                else
                begin
                    cmd.commit = 1'b1;
                    if (sts.func == bfsa_pkg::FUNC_ALLOC && sts.do_split)
                    begin
                        split_next = 1'b1; state_next = S_SHRD;
                    end else state_next = S_DONE;
                end
            S_SHRD:
                if (sts.shift_end) state_next = S_DONE;
                else
                begin
                    cmd.shift_rd = 1'b1; state_next = S_SHWR;
                end
            S_SHWR:
            begin
                cmd.shift_wr = 1'b1; state_next = S_SHRD;
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.init_last)
                begin
                    // the pass after reset gives no result
                    cmd.init_done = 1'b1; boot_next = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
                cmd.ins = split_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT; split_reg <= 1'b0; boot_reg <= 1'b1;
        end else
        begin
            state_reg <= state_next; split_reg <= split_next; boot_reg <= boot_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("accept while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |=> out_valid)
        else $error("result not presented");
endmodule
`default_nettype wire

FILE: sv/best_fit_segment_allocator_unit.sv
`default_nettype none
// Best-fit segment allocator.
// Input channel (in_valid/in_ready): func, size_bytes, address. One
// transaction in gives exactly one result transaction out (out_valid/
// out_ready): payload_address, status, split_done.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// heap_base, index 1 heap_length; always ready. New values apply only on a
// reinitialize request.
// One request in flight at a time. Allocate/free scan the table with one
// read and one compare per entry through the single table port. When a split
// inserts a new chunk, the entries above it are moved up one place (a read and
// a write each) and the new chunk is written; then the result is presented.
// Reinitialize writes one table entry per cycle. After each result the unit
// returns to idle before the next request is taken.
// Reset restores both registers to 65536 and the count to one, then runs a
// table initialisation pass over all MAX_CHUNKS entries with in_ready held low.
// While out_ready is low the result is held and no new request is taken.
module best_fit_segment_allocator_unit #(
    parameter int MAX_CHUNKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] size_bytes,
    input  wire logic [31:0] address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      payload_address,
    output logic [1:0]       status,
    output logic             split_done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    bfsa_pkg::cmd_t cmd;
    bfsa_pkg::sts_t sts;
    logic [31:0] heap_base_reg, heap_length_reg;

    assign cfg_ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg   <= bfsa_pkg::RESET_HEAP_BASE;
            heap_length_reg <= bfsa_pkg::RESET_HEAP_LENGTH;
        end else if (cfg_valid)
        begin
            if (cfg_index == bfsa_pkg::CFG_HEAP_BASE) heap_base_reg <= cfg_data;
            else heap_length_reg <= cfg_data;
        end
    end

    bfsa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .sts(sts)
    );

    bfsa_datapath #(.MAX_CHUNKS(MAX_CHUNKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .func(func), .size_bytes(size_bytes), .address(address),
        .heap_base(heap_base_reg), .heap_length(heap_length_reg),
        .payload_address(payload_address), .status(status),
        .split_done(split_done)
    );
endmodule
`default_nettype wire
